FILE: sv/lhp_pkg.sv
package lhp_pkg;

  localparam int unsigned CNT_W   = 24;
  localparam int unsigned OUT_W   = 24;
  localparam int unsigned BINS    = 256;
  localparam int unsigned BIN_W   = $clog2(BINS);
  localparam int unsigned PIX_W   = 8;
  localparam int unsigned WGT_W   = 16;
  localparam int unsigned PROD_W  = PIX_W + WGT_W;
  localparam int unsigned ACC_W   = PROD_W + 1;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned LUMA_W  = ACC_W - FRAC_W;

  localparam logic [WGT_W-1:0] W_RED      = 16'd13933;
  localparam logic [WGT_W-1:0] W_GREEN    = 16'd46871;
  localparam logic [WGT_W-1:0] W_BLUE     = 16'd4732;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  localparam logic [BIN_W-1:0] PEAK_LO = BIN_W'(2);
  localparam logic [BIN_W-1:0] PEAK_HI = BIN_W'(253);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  typedef enum logic [1:0] {
    ACT_PIXEL = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2
  } lhp_action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_RD_PIX,
    ST_UPDATE,
    ST_RD_BIN,
    ST_RESP
  } lhp_state_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic mul;
    logic sum;
    logic rd;
    logic update;
    logic respond;
  } lhp_cmd_t;

  function automatic logic [OUT_W-1:0] to_out(logic [CNT_W-1:0] v);
    logic [CNT_W+OUT_W-1:0] w;
    logic [CNT_W+OUT_W-1:0] lim;
    w   = {{OUT_W{1'b0}}, v};
    lim = {{CNT_W{1'b0}}, OUT_MAX};
    if (w > lim) begin
      return OUT_MAX;
    end
    return w[OUT_W-1:0];
  endfunction

endpackage

FILE: sv/lhp_ctrl.sv
module lhp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        action_i,
  output logic              busy_o,
  output lhp_pkg::lhp_cmd_t cmd_o
);

  lhp_pkg::lhp_state_e state_q, state_d;
  logic                accept;

  assign busy_o = (state_q != lhp_pkg::ST_IDLE);
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lhp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lhp_pkg::ST_IDLE: begin
        if (accept) begin
          case (lhp_pkg::lhp_action_e'(action_i))
            lhp_pkg::ACT_PIXEL: state_d = lhp_pkg::ST_MUL;
            lhp_pkg::ACT_READ:  state_d = lhp_pkg::ST_RD_BIN;
            default:            state_d = lhp_pkg::ST_IDLE;
          endcase
        end
      end
      lhp_pkg::ST_MUL:    state_d = lhp_pkg::ST_SUM;
      lhp_pkg::ST_SUM:    state_d = lhp_pkg::ST_RD_PIX;
      lhp_pkg::ST_RD_PIX: state_d = lhp_pkg::ST_UPDATE;
      lhp_pkg::ST_UPDATE: state_d = lhp_pkg::ST_IDLE;
      lhp_pkg::ST_RD_BIN: state_d = lhp_pkg::ST_RESP;
      lhp_pkg::ST_RESP:   state_d = lhp_pkg::ST_IDLE;
      default:            state_d = lhp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      lhp_pkg::ST_IDLE: begin
        cmd_o.load  = accept;
        cmd_o.clear = accept && (lhp_pkg::lhp_action_e'(action_i) == lhp_pkg::ACT_CLEAR);
      end
      lhp_pkg::ST_MUL:    cmd_o.mul     = 1'b1;
      lhp_pkg::ST_SUM:    cmd_o.sum     = 1'b1;
      lhp_pkg::ST_RD_PIX: cmd_o.rd      = 1'b1;
      lhp_pkg::ST_UPDATE: cmd_o.update  = 1'b1;
      lhp_pkg::ST_RD_BIN: cmd_o.rd      = 1'b1;
      lhp_pkg::ST_RESP:   cmd_o.respond = 1'b1;
      default:            cmd_o = '0;
    endcase
  end

  a_pixel_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (action_i == lhp_pkg::ACT_PIXEL) |=> ##3 state_q == lhp_pkg::ST_UPDATE)
    else $error("pixel item did not reach update");

  a_resp_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.respond |-> $past(state_q) == lhp_pkg::ST_RD_BIN)
    else $error("response without bin read");

  a_read_responds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (action_i == lhp_pkg::ACT_READ) |=> ##1 cmd_o.respond)
    else $error("read item gave no response");

endmodule

FILE: sv/lhp_datapath.sv
module lhp_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lhp_pkg::lhp_cmd_t           cmd_i,
  input  logic [lhp_pkg::PIX_W-1:0]   red_i,
  input  logic [lhp_pkg::PIX_W-1:0]   green_i,
  input  logic [lhp_pkg::PIX_W-1:0]   blue_i,
  input  logic [lhp_pkg::BIN_W-1:0]   bin_index_i,
  output logic [lhp_pkg::OUT_W-1:0]   bin_count_o,
  output logic [lhp_pkg::OUT_W-1:0]   peak_count_o
);

  logic [lhp_pkg::PIX_W-1:0]  red_q, green_q, blue_q;
  logic [lhp_pkg::PROD_W-1:0] prod_r_q, prod_g_q, prod_b_q;
  logic [lhp_pkg::BIN_W-1:0]  addr_q;
  logic [lhp_pkg::CNT_W-1:0]  mem_q [lhp_pkg::BINS];
  logic [lhp_pkg::BINS-1:0]   valid_q;
  logic [lhp_pkg::CNT_W-1:0]  rdata_q;
  logic                       rd_valid_q;
  logic [lhp_pkg::CNT_W-1:0]  peak_q;

  logic [lhp_pkg::ACC_W-1:0]  acc;
  logic [lhp_pkg::LUMA_W-1:0] luma;
  logic [lhp_pkg::BIN_W-1:0]  luma_bin;
  logic [lhp_pkg::CNT_W-1:0]  cur_cnt;
  logic [lhp_pkg::CNT_W-1:0]  new_cnt;
  logic                       in_peak;

  assign acc = lhp_pkg::ACC_W'(prod_r_q) + lhp_pkg::ACC_W'(prod_g_q)
             + lhp_pkg::ACC_W'(prod_b_q) + lhp_pkg::ROUND_HALF;
  assign luma = acc[lhp_pkg::ACC_W-1:lhp_pkg::FRAC_W];
  assign luma_bin = (luma > lhp_pkg::LUMA_W'(lhp_pkg::BINS - 1)) ? '1
                                                                  : luma[lhp_pkg::BIN_W-1:0];

  assign cur_cnt = rd_valid_q ? rdata_q : '0;
  assign new_cnt = (cur_cnt == lhp_pkg::CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
  assign in_peak = (addr_q >= lhp_pkg::PEAK_LO) && (addr_q <= lhp_pkg::PEAK_HI);

  assign bin_count_o  = lhp_pkg::to_out(cur_cnt);
  assign peak_count_o = lhp_pkg::to_out((peak_q == '0) ? lhp_pkg::CNT_W'(1) : peak_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
    end
    if (cmd_i.mul) begin
      prod_r_q <= lhp_pkg::PROD_W'(red_q) * lhp_pkg::PROD_W'(lhp_pkg::W_RED);
      prod_g_q <= lhp_pkg::PROD_W'(green_q) * lhp_pkg::PROD_W'(lhp_pkg::W_GREEN);
      prod_b_q <= lhp_pkg::PROD_W'(blue_q) * lhp_pkg::PROD_W'(lhp_pkg::W_BLUE);
    end
    if (cmd_i.load) begin
      addr_q <= bin_index_i;
    end else if (cmd_i.sum) begin
      addr_q <= luma_bin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rdata_q <= mem_q[addr_q];
    end
    if (cmd_i.update) begin
      mem_q[addr_q] <= new_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      peak_q     <= '0;
    end else begin
      if (cmd_i.rd) begin
        rd_valid_q <= valid_q[addr_q];
      end
      if (cmd_i.clear) begin
        valid_q <= '0;
        peak_q  <= '0;
      end else if (cmd_i.update) begin
        valid_q[addr_q] <= 1'b1;
        if (in_peak && (new_cnt > peak_q)) begin
          peak_q <= new_cnt;
        end
      end
    end
  end

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (peak_q == '0) && (valid_q == '0))
    else $error("clear left state behind");

  a_update_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> valid_q[$past(addr_q)])
    else $error("updated bin not marked valid");

  a_peak_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.clear |=> peak_q >= $past(peak_q))
    else $error("peak decreased without clear");

endmodule

FILE: sv/luma_histogram_peak_core.sv
// Pixel item: busy through multiply, sum, bin read and update; no item taken while busy.
// Read item: valid_o pulses in the response state after the bin read; busy until then.
// Clear item: done at the accepting edge; the next item may follow at once.
// Pixel rate is set by the multiply, sum and single-port bin memory read-modify-write.
// rst_ni (async, active low) empties every bin and the peak; results cannot stall.
module luma_histogram_peak_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [1:0]                action_i,
  input  logic [lhp_pkg::PIX_W-1:0] red_i,
  input  logic [lhp_pkg::PIX_W-1:0] green_i,
  input  logic [lhp_pkg::PIX_W-1:0] blue_i,
  input  logic [lhp_pkg::BIN_W-1:0] bin_index_i,
  output logic                      valid_o,
  output logic [lhp_pkg::OUT_W-1:0] bin_count_o,
  output logic [lhp_pkg::OUT_W-1:0] peak_count_o
);

  lhp_pkg::lhp_cmd_t cmd;

  lhp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .busy_o   (busy_o),
    .cmd_o    (cmd)
  );

  lhp_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .bin_index_i  (bin_index_i),
    .bin_count_o  (bin_count_o),
    .peak_count_o (peak_count_o)
  );

  assign valid_o = cmd.respond;

endmodule
